>>> rtl/core/multiway_sorted_list_intersection_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef MULTIWAY_SORTED_LIST_INTERSECTION_TOP_MACROS_SVH
`define MULTIWAY_SORTED_LIST_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define MSLI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msli check failed");

// Next-cycle implication, inactive during reset.
`define MSLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msli check failed");

`endif

>>> rtl/core/msli_pkg.sv
package msli_pkg;

  localparam int MSLI_MAX_LIST_LEN = 1024;
  localparam int MSLI_ID_BITS      = 32;
  localparam int MSLI_TOTAL_BITS   = 11;

  typedef struct packed {
    logic [31:0] vertex_id;
    logic        has_element;
    logic        is_first_list;
    logic        end_of_list;
    logic        final_list;
  } msli_item_t;

  typedef struct packed {
    logic [31:0]                match_id;
    logic                       match_valid;
    logic                       query_done;
    logic [MSLI_TOTAL_BITS-1:0] match_total;
    logic                       overflowed;
  } msli_result_t;

  // Result produced by the engine in the current cycle.
  typedef struct packed {
    logic         fire;
    msli_result_t payload;
  } msli_evt_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } msli_state_t;

endpackage

>>> rtl/core/msli_engine.sv
module msli_engine
  import msli_pkg::*;
#(
  parameter int MAX_LIST_LEN = MSLI_MAX_LIST_LEN,
  parameter int ID_BITS      = MSLI_ID_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  msli_item_t item,
  output logic       busy,
  output msli_evt_t  evt
);

  localparam int AddrW  = $clog2(MAX_LIST_LEN);
  localparam int CntW   = $clog2(MAX_LIST_LEN + 1);
  localparam int StoreW = (ID_BITS < 32) ? ID_BITS : 32;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LIST_LEN);

  // Running set; compacted in place. While a later list is merged, writes land at
  // or below the read pointer; a read of the entry being written returns old data.
  logic [StoreW-1:0] store [MAX_LIST_LEN];
  logic [StoreW-1:0] rd_data;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [AddrW-1:0]  mem_raddr;
  logic [StoreW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[mem_raddr];
  end

  msli_state_t       state, state_next;
  logic              list_open, list_open_next;
  logic              cur_first, cur_first_next;
  logic              cur_final, cur_final_next;
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   rp, rp_next;
  logic [CntW-1:0]   wp, wp_next;
  logic              ovf, ovf_next;
  logic [StoreW-1:0] key, key_next;
  logic              key_eol, key_eol_next;

  logic [StoreW-1:0]      hit_id;
  logic                   mv;
  logic                   done;
  logic                   close;
  logic                   fin_flag;
  logic [StoreW+31:0]     id_ext;
  logic [CntW+MSLI_TOTAL_BITS-1:0] total_ext;

  always_comb begin
    logic             opening;
    logic             eff_first;
    logic             eff_final;
    logic [StoreW-1:0] v;
    opening        = 1'b0;
    eff_first      = cur_first;
    eff_final      = cur_final;
    v              = item.vertex_id[StoreW-1:0];
    state_next     = state;
    list_open_next = list_open;
    cur_first_next = cur_first;
    cur_final_next = cur_final;
    count_next     = count;
    rp_next        = rp;
    wp_next        = wp;
    ovf_next       = ovf;
    key_next       = key;
    key_eol_next   = key_eol;
    mem_we         = 1'b0;
    mem_waddr      = wp[AddrW-1:0];
    mem_wdata      = key;
    mem_raddr      = rp[AddrW-1:0];
    mv             = 1'b0;
    close          = 1'b0;
    fin_flag       = cur_final;
    hit_id         = '0;
    unique case (state)
      ST_IDLE: begin
        if (start && (item.has_element || item.end_of_list)) begin
          opening        = !list_open;
          eff_first      = opening ? item.is_first_list : cur_first;
          eff_final      = opening ? item.final_list : cur_final;
          fin_flag       = eff_final;
          list_open_next = 1'b1;
          cur_first_next = eff_first;
          cur_final_next = eff_final;
          if (opening) begin
            rp_next = '0;
            wp_next = '0;
            if (item.is_first_list) begin
              count_next = '0;
              ovf_next   = 1'b0;
            end
          end
          if (eff_first) begin
            if (item.has_element) begin
              if (wp_next < MaxCnt) begin
                mem_we    = 1'b1;
                mem_waddr = wp_next[AddrW-1:0];
                mem_wdata = v;
                wp_next   = wp_next + CntW'(1);
                mv        = eff_final;
                hit_id    = v;
              end else begin
                ovf_next = 1'b1;
              end
            end
            close = item.end_of_list;
          end else if (item.has_element && (rp_next < count_next)) begin
            // Fetch the stored head; compare next cycle.
            mem_raddr    = rp_next[AddrW-1:0];
            key_next     = v;
            key_eol_next = item.end_of_list;
            state_next   = ST_CMP;
          end else begin
            close = item.end_of_list;
          end
        end
      end
      ST_CMP: begin
        if (rd_data < key) begin
          // Skip the smaller stored element, keep fetching while any remain.
          rp_next = rp + CntW'(1);
          if (rp_next < count) begin
            mem_raddr = rp_next[AddrW-1:0];
          end else begin
            close      = key_eol;
            state_next = ST_IDLE;
          end
        end else if (rd_data == key) begin
          mem_we     = 1'b1;
          mem_waddr  = wp[AddrW-1:0];
          mem_wdata  = key;
          wp_next    = wp + CntW'(1);
          rp_next    = rp + CntW'(1);
          mv         = cur_final;
          hit_id     = key;
          close      = key_eol;
          state_next = ST_IDLE;
        end else begin
          close      = key_eol;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    done = 1'b0;
    if (close) begin
      count_next     = wp_next;
      list_open_next = 1'b0;
      done           = fin_flag;
    end
  end

  assign id_ext    = {32'b0, hit_id};
  assign total_ext = {{MSLI_TOTAL_BITS{1'b0}}, wp_next};

  always_comb begin
    evt.fire                = mv | done;
    evt.payload.match_id    = id_ext[31:0];
    evt.payload.match_valid = mv;
    evt.payload.query_done  = done;
    evt.payload.match_total = done ? total_ext[MSLI_TOTAL_BITS-1:0] : '0;
    evt.payload.overflowed  = ovf_next;
  end

  assign busy = (state == ST_CMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      list_open <= 1'b0;
      cur_first <= 1'b0;
      cur_final <= 1'b0;
      count     <= '0;
      rp        <= '0;
      wp        <= '0;
      ovf       <= 1'b0;
      key_eol   <= 1'b0;
    end else begin
      state     <= state_next;
      list_open <= list_open_next;
      cur_first <= cur_first_next;
      cur_final <= cur_final_next;
      count     <= count_next;
      rp        <= rp_next;
      wp        <= wp_next;
      ovf       <= ovf_next;
      key_eol   <= key_eol_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

>>> rtl/core/multiway_sorted_list_intersection_top.sv
// Latency: the result beat appears in the cycle after the item's last work cycle.
// First-list items and items needing no compare are accepted back to back; busy stays low.
// A later-list element with stored ids left raises busy and compares stored ids one at
// a time (each skipped id and the one it stops on) through the single read port.
// Reset clears control state and counts; the running-set memory is not cleared.
module multiway_sorted_list_intersection_top
  import msli_pkg::*;
#(
  parameter int MAX_LIST_LEN = MSLI_MAX_LIST_LEN,
  parameter int ID_BITS      = MSLI_ID_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  msli_item_t   item,
  output logic         busy,
  output logic         result_valid,
  output msli_result_t result
);

  msli_evt_t evt;

  msli_engine #(
    .MAX_LIST_LEN (MAX_LIST_LEN),
    .ID_BITS      (ID_BITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .evt   (evt)
  );

  // Output beat register: one-cycle strobe, payload held until the next beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= evt.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.fire) begin
      result <= evt.payload;
    end
  end

endmodule

>>> rtl/core/msli_checker.sv
`include "multiway_sorted_list_intersection_top_macros.svh"

module msli_checker
  import msli_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         start,
  input msli_item_t   item,
  input logic         busy,
  input logic         result_valid,
  input msli_result_t result
);

  logic accepted;
  logic beat_no_hit;
  logic beat_no_done;
  logic idle_take;
  assign accepted     = start && !busy;
  assign beat_no_hit  = result_valid && !result.match_valid;
  assign beat_no_done = result_valid && !result.query_done;
  assign idle_take    = accepted && !item.has_element;

  `MSLI_ASSERT_IMPLY(a_beat_has_content, clk, rst, result_valid, result.match_valid || result.query_done)
  `MSLI_ASSERT_IMPLY(a_id_zero_without_match, clk, rst, beat_no_hit, result.match_id == 32'd0)
  `MSLI_ASSERT_IMPLY(a_total_only_when_done, clk, rst, beat_no_done, result.match_total == '0)
  `MSLI_ASSERT_NEXT(a_busy_needs_element, clk, rst, idle_take, !busy)

endmodule

bind multiway_sorted_list_intersection_top msli_checker u_msli_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .item         (item),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

>>> tb/multiway_sorted_list_intersection_top_tb.sv
`timescale 1ns / 1ps

module multiway_sorted_list_intersection_top_tb;
  import msli_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 260;
  localparam int DRAIN_CYCLES  = 1100;
  localparam int OVERFLOW_LEN  = MSLI_MAX_LIST_LEN + 2;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  msli_item_t   item = '0;
  logic         busy;
  logic         result_valid;
  msli_result_t result;

  multiway_sorted_list_intersection_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always #6 clk = ~clk;

  // Shadow of the running set and merge pointers
  logic [31:0]  set_ids [MSLI_MAX_LIST_LEN];
  int           set_count = 0;
  int           scan_pos = 0;
  int           fill_pos = 0;
  bit           drop_flag = 0;
  bit           list_active = 0;
  bit           list_is_first = 0;
  bit           list_is_final = 0;

  msli_result_t pending_results [$];
  msli_result_t check_want;
  logic [31:0]  list_buf [$];
  int           error_count = 0;
  int           sent_items = 0;
  int           cycle_count = 0;
  bit           no_gaps = 0;

  task automatic intersect_predict(input msli_item_t it);
    msli_result_t r;
    bit hit;
    bit done;
    r = '0;
    hit = 0;
    done = 0;
    if (!it.has_element && !it.end_of_list) return;
    if (!list_active) begin
      list_active   = 1;
      list_is_first = it.is_first_list;
      list_is_final = it.final_list;
      scan_pos = 0;
      fill_pos = 0;
      if (list_is_first) begin
        drop_flag = 0;
        set_count = 0;
      end
    end
    if (it.has_element) begin
      if (list_is_first) begin
        if (fill_pos < MSLI_MAX_LIST_LEN) begin
          set_ids[fill_pos] = it.vertex_id;
          fill_pos++;
          hit = list_is_final;
        end else begin
          drop_flag = 1;
        end
      end else begin
        // advance past stored ids below the incoming one, never backwards
        while (scan_pos < set_count && set_ids[scan_pos] < it.vertex_id) scan_pos++;
        if (scan_pos < set_count && set_ids[scan_pos] == it.vertex_id) begin
          if (fill_pos < MSLI_MAX_LIST_LEN) begin
            set_ids[fill_pos] = it.vertex_id;
            fill_pos++;
          end
          scan_pos++;
          hit = list_is_final;
        end
      end
    end
    if (it.end_of_list) begin
      set_count   = fill_pos;
      list_active = 0;
      done        = list_is_final;
    end
    if (hit || done) begin
      r.match_id    = hit ? it.vertex_id : '0;
      r.match_valid = hit;
      r.query_done  = done;
      r.match_total = done ? MSLI_TOTAL_BITS'(fill_pos) : '0;
      r.overflowed  = drop_flag;
      pending_results = {pending_results, r};
    end
  endtask

  // Present one item from a falling edge and hold it until the engine takes it
  task automatic send_item(input msli_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (it.has_element || it.end_of_list) sent_items++;
    intersect_predict(it);
  endtask

  task automatic send_list(input bit first, input bit fin, input bit sep_end, input bit noisy);
    msli_item_t it;
    int n;
    n = list_buf.size();
    if (n == 0) sep_end = 1;
    for (int j = 0; j < n; j++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        it.vertex_id     = $urandom;
        it.has_element   = 1'b0;
        it.is_first_list = 1'($urandom);
        it.end_of_list   = 1'b0;
        it.final_list    = 1'($urandom);
        send_item(it);
      end
      it.vertex_id   = list_buf[j];
      it.has_element = 1'b1;
      it.end_of_list = (j == n - 1) && !sep_end;
      if (j == 0 || !noisy) begin
        it.is_first_list = first;
        it.final_list    = fin;
      end else begin
        it.is_first_list = 1'($urandom);
        it.final_list    = 1'($urandom);
      end
      send_item(it);
    end
    if (sep_end) begin
      it.vertex_id   = $urandom;
      it.has_element = 1'b0;
      it.end_of_list = 1'b1;
      if (n == 0 || !noisy) begin
        it.is_first_list = first;
        it.final_list    = fin;
      end else begin
        it.is_first_list = 1'($urandom);
        it.final_list    = 1'($urandom);
      end
      send_item(it);
    end
  endtask

  task automatic test_before_first_list();
    list_buf = {32'd5};
    send_list(1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_single_list_query();
    list_buf = {32'd0, 32'd5, 32'hFFFF_FFFF};
    send_list(1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_two_list_query();
    msli_item_t idle;
    idle.vertex_id     = 32'hA5A5_5A5A;
    idle.has_element   = 1'b0;
    idle.is_first_list = 1'b1;
    idle.end_of_list   = 1'b0;
    idle.final_list    = 1'b1;
    send_item(idle);
    list_buf = {32'd1, 32'd7, 32'd9, 32'hFFFF_FFFE};
    send_list(1'b1, 1'b0, 1'b1, 1'b0);
    list_buf = {32'd7, 32'd8, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    send_list(1'b0, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_empty_set();
    list_buf.delete();
    send_list(1'b1, 1'b0, 1'b1, 1'b0);
    send_list(1'b0, 1'b0, 1'b1, 1'b0);
    list_buf = {32'd3};
    send_list(1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_duplicates();
    list_buf = {32'd4, 32'd4, 32'd6};
    send_list(1'b1, 1'b0, 1'b0, 1'b0);
    list_buf = {32'd4, 32'd4, 32'd4, 32'd6, 32'd5};
    send_list(1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // Fill past capacity as a first-and-final list, then merge a list that matches the first and last stored ids
  task automatic test_overflow();
    list_buf.delete();
    for (int i = 0; i < OVERFLOW_LEN; i++) list_buf = {list_buf, 32'(3 * i + 1)};
    send_list(1'b1, 1'b1, 1'b0, 1'b0);
    list_buf = {32'd1, 32'(3 * (MSLI_MAX_LIST_LEN - 1) + 1),
                32'(3 * MSLI_MAX_LIST_LEN + 1), 32'hFFFF_FFFF};
    send_list(1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic run_random_query();
    logic [31:0] uni [$];
    logic [63:0] v;
    logic [63:0] span;
    int usize;
    int step;
    int nlists;
    int mode;
    bit broken;
    bit first;
    bit fin;
    usize = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 16);
    step  = 1 << $urandom_range(0, 24);
    span  = 64'(usize) * 64'(step);
    mode  = $urandom_range(0, 3);
    case (mode)
      0: v = 64'd0;
      1: v = (span < 64'hFFFF_FFFF) ? 64'hFFFF_FFFF - span : 64'd0;
      default: v = 64'($urandom);
    endcase
    for (int i = 0; i < usize; i++) begin
      if (v > 64'hFFFF_FFFF) break;
      uni = {uni, v[31:0]};
      v = v + 64'($urandom_range(1, step));
    end
    if (mode == 1 && uni[uni.size() - 1] != 32'hFFFF_FFFF) uni = {uni, 32'hFFFF_FFFF};
    broken = ($urandom_range(0, 9) == 0);
    nlists = $urandom_range(1, 5);
    for (int l = 0; l < nlists; l++) begin
      list_buf.delete();
      if ($urandom_range(0, 11) != 0) begin
        if (broken) begin
          repeat ($urandom_range(1, uni.size()))
            list_buf = {list_buf, uni[$urandom_range(0, uni.size() - 1)]};
        end else begin
          foreach (uni[k])
            if ($urandom_range(0, 9) < ((l == 0) ? 9 : 7)) list_buf = {list_buf, uni[k]};
        end
      end
      first = (l == 0);
      fin   = (l == nlists - 1);
      if (broken) begin
        first = 1'($urandom);
        fin   = 1'($urandom);
      end
      send_list(first, fin, $urandom_range(0, 2) == 0, broken || $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random();
    int base;
    int query_no;
    base = sent_items;
    query_no = 0;
    while (sent_items < base + RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      run_random_query();
      query_no++;
      // hold off until every expected beat has come back
      if (query_no % 4 == 1) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    no_gaps = 0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: id=%h mv=%b done=%b total=%0d ovf=%b",
                   result.match_id, result.match_valid, result.query_done,
                   result.match_total, result.overflowed);
      end else begin
        check_want = pending_results.pop_front();
        if (result.match_id !== check_want.match_id ||
            result.match_valid !== check_want.match_valid ||
            result.query_done !== check_want.query_done ||
            result.match_total !== check_want.match_total ||
            result.overflowed !== check_want.overflowed) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp id=%h mv=%b done=%b total=%0d ovf=%b,",
                     check_want.match_id, check_want.match_valid, check_want.query_done,
                     check_want.match_total, check_want.overflowed,
                     " got id=%h mv=%b done=%b total=%0d ovf=%b",
                     result.match_id, result.match_valid, result.query_done,
                     result.match_total, result.overflowed);
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_before_first_list();
    test_single_list_query();
    test_two_list_query();
    test_empty_set();
    test_duplicates();
    test_overflow();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
